### rtl/core/ros_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ros_pkg: shared types and codes of the rectangle overlap scanner
// slot record, query box edges, opcode and kind codes, kind translation
// ----------------------------------------------------------------------------
package ros_pkg;

	localparam int ENTRIES_DEF = 32;

	localparam int ID_W     = 16;
	localparam int COORD_W  = 16;
	localparam int SIZE_W   = 12;
	localparam int KIND_W   = 3;
	localparam int SLOT_W   = 5;
	// edge = coordinate + size, kept signed without wrap
	localparam int EDGE_W   = 18;
	// wide enough to hold any slot number and the largest table depth
	localparam int WIDX_W   = 7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// entry kinds as written
	localparam logic [KIND_W-1:0] EK_NONE   = 3'd0;
	localparam logic [KIND_W-1:0] EK_WALL   = 3'd1;
	localparam logic [KIND_W-1:0] EK_LADDER = 3'd2;
	localparam logic [KIND_W-1:0] EK_NPC    = 3'd3;
	localparam logic [KIND_W-1:0] EK_RESET  = 3'd4;
	localparam logic [KIND_W-1:0] EK_LEND   = 3'd5;
	localparam logic [KIND_W-1:0] EK_LBEGIN = 3'd6;

	// collision kinds as reported
	localparam logic [KIND_W-1:0] CK_REGULAR = 3'd0;
	localparam logic [KIND_W-1:0] CK_LADDER  = 3'd1;
	localparam logic [KIND_W-1:0] CK_RESET   = 3'd2;
	localparam logic [KIND_W-1:0] CK_LEND    = 3'd3;
	localparam logic [KIND_W-1:0] CK_LBEGIN  = 3'd4;
	localparam logic [KIND_W-1:0] CK_UNSPEC  = 3'd5;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic        [SIZE_W-1:0]  w;
		logic        [SIZE_W-1:0]  h;
		logic        [KIND_W-1:0]  kind;
	} slot_t;

	typedef struct packed {
		logic signed [EDGE_W-1:0] left;
		logic signed [EDGE_W-1:0] right;
		logic signed [EDGE_W-1:0] top;
		logic signed [EDGE_W-1:0] bottom;
	} box_t;

	// none, npc and the spare code have no collision meaning
	function automatic logic [KIND_W-1:0] map_kind(input logic [KIND_W-1:0] k);
		logic [KIND_W-1:0] r;
		unique case (k)
			EK_WALL:   r = CK_REGULAR;
			EK_LADDER: r = CK_LADDER;
			EK_RESET:  r = CK_RESET;
			EK_LEND:   r = CK_LEND;
			EK_LBEGIN: r = CK_LBEGIN;
			default:   r = CK_UNSPEC;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/rectangle_overlap_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_overlap_scanner: table of collidable rectangles with box query
// a write word fills one slot; a query word scans all slots in index order
// and reports every valid slot that the moved box overlaps
// ----------------------------------------------------------------------------
// A write word (opcode 0) leaves busy low, and the next word may follow at
// once. A query word (opcode 1) keeps busy high until its closing result word
// is registered: the slot memory has one read port and is read one slot per
// cycle, and each slot then passes the read stage and the compare stage.
// Results appear on strobe, one per cycle at most, and cannot be held off by
// the receiver; they come in ascending slot order and the final one of each
// query carries last. A query that overlaps nothing gives a single word with
// hit low and last high. There is no clearing pass: slot valid bits are
// flip-flops cleared by reset, so the block takes words right after reset.
// ----------------------------------------------------------------------------
module rectangle_overlap_scanner #(
	parameter int ENTRIES = ros_pkg::ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               opcode,
	input  logic [ros_pkg::SLOT_W-1:0]         entry_index,
	input  logic [ros_pkg::ID_W-1:0]           mover_id,
	input  logic signed [ros_pkg::COORD_W-1:0] box_x,
	input  logic signed [ros_pkg::COORD_W-1:0] box_y,
	input  logic [ros_pkg::SIZE_W-1:0]         box_width,
	input  logic [ros_pkg::SIZE_W-1:0]         box_height,
	input  logic [ros_pkg::KIND_W-1:0]         entry_kind,
	input  logic                               entry_valid,
	output logic                               strobe,
	output logic [ros_pkg::ID_W-1:0]           hit_mover,
	output logic [ros_pkg::SLOT_W-1:0]         hit_index,
	output logic [ros_pkg::KIND_W-1:0]         collision_kind,
	output logic                               hit,
	output logic                               last
);
	import ros_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q;

	// slot storage: one synchronous memory, valid bits in flops
	slot_t              slot_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	// query context
	box_t            box_q;
	logic [ID_W-1:0] mover_q;
	logic [CNT_W-1:0] cnt_q;

	// read stage
	slot_t            slot_s1;
	logic             act_s1;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	// compare stage
	logic              act_s2;
	logic              hit_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [KIND_W-1:0] kind_s2;

	// one hit held back so the final one can be marked last
	logic              pend_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic [KIND_W-1:0] pend_kind_q;

	// result word
	logic              strobe_q;
	logic [ID_W-1:0]   mover_out_q;
	logic [SLOT_W-1:0] index_out_q;
	logic [KIND_W-1:0] kind_out_q;
	logic              hit_out_q;
	logic              last_out_q;

	logic              accept;
	logic [WIDX_W-1:0] widx_ext;
	logic [IDX_W-1:0]  waddr;
	logic              wr_en;
	logic              issue;
	logic [IDX_W-1:0]  rd_addr;
	logic              scan_end;
	logic              emit_mid;

	assign busy     = (state_q == ST_SCAN);
	assign accept   = start && !busy;

	// writes beyond the table are dropped
	assign widx_ext = WIDX_W'(entry_index);
	assign waddr    = widx_ext[IDX_W-1:0];
	assign wr_en    = accept && (opcode == OP_WRITE) && (widx_ext < WIDX_W'(ENTRIES));

	assign issue    = (state_q == ST_SCAN) && (cnt_q < CNT_W'(ENTRIES));
	assign rd_addr  = cnt_q[IDX_W-1:0];

	// all slots read and both stages drained
	assign scan_end = (state_q == ST_SCAN) && !issue && !act_s1 && !act_s2;

	// a new hit pushes the held one out as a middle word
	assign emit_mid = hit_s2 && pend_q;

	// memory port: write on a write word, registered read during the scan
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[waddr] <= '{x: box_x, y: box_y, w: box_width, h: box_height,
			                     kind: entry_kind};
		end
		if (issue) begin
			slot_s1 <= slot_mem[rd_addr];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			valid_q  <= '0;
			act_s1   <= 1'b0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			act_s1   <= issue;
			strobe_q <= emit_mid || scan_end;
			if (wr_en) begin
				valid_q[waddr] <= entry_valid;
			end
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (hit_s2) begin
				pend_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == OP_QUERY)) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						pend_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query context and read stage payload
	always_ff @(posedge clk) begin
		if (accept && (opcode == OP_QUERY)) begin
			mover_q       <= mover_id;
			box_q.left    <= EDGE_W'(box_x);
			box_q.top     <= EDGE_W'(box_y);
			box_q.right   <= EDGE_W'(box_x) + EDGE_W'($signed({1'b0, box_width}));
			box_q.bottom  <= EDGE_W'(box_y) + EDGE_W'($signed({1'b0, box_height}));
		end
		if (issue) begin
			vld_s1 <= valid_q[rd_addr];
			idx_s1 <= rd_addr;
		end else begin
			vld_s1 <= 1'b0;
		end
	end

	ros_overlap #(
		.IDX_W (IDX_W)
	) u_overlap (
		.clk     (clk),
		.arst_n  (arst_n),
		.act_s1  (act_s1),
		.vld_s1  (vld_s1),
		.idx_s1  (idx_s1),
		.slot_s1 (slot_s1),
		.box     (box_q),
		.act_s2  (act_s2),
		.hit_s2  (hit_s2),
		.idx_s2  (idx_s2),
		.kind_s2 (kind_s2)
	);

	// held hit and result word payload
	always_ff @(posedge clk) begin
		if (hit_s2) begin
			pend_idx_q  <= idx_s2;
			pend_kind_q <= map_kind(kind_s2);
		end
		if (emit_mid) begin
			mover_out_q <= mover_q;
			index_out_q <= SLOT_W'(pend_idx_q);
			kind_out_q  <= pend_kind_q;
			hit_out_q   <= 1'b1;
			last_out_q  <= 1'b0;
		end else if (scan_end) begin
			mover_out_q <= mover_q;
			last_out_q  <= 1'b1;
			if (pend_q) begin
				index_out_q <= SLOT_W'(pend_idx_q);
				kind_out_q  <= pend_kind_q;
				hit_out_q   <= 1'b1;
			end else begin
				// empty query closing word
				index_out_q <= '0;
				kind_out_q  <= CK_REGULAR;
				hit_out_q   <= 1'b0;
			end
		end
	end

	assign strobe         = strobe_q;
	assign hit_mover      = mover_out_q;
	assign hit_index      = index_out_q;
	assign collision_kind = kind_out_q;
	assign hit            = hit_out_q;
	assign last           = last_out_q;

endmodule

### rtl/core/ros_overlap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ros_overlap: slot versus box overlap test
// registers the slot's edges, then checks strict edge containment
// ----------------------------------------------------------------------------
module ros_overlap #(
	parameter int IDX_W = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        act_s1,
	input  logic                        vld_s1,
	input  logic [IDX_W-1:0]            idx_s1,
	input  ros_pkg::slot_t              slot_s1,
	input  ros_pkg::box_t               box,
	output logic                        act_s2,
	output logic                        hit_s2,
	output logic [IDX_W-1:0]            idx_s2,
	output logic [ros_pkg::KIND_W-1:0]  kind_s2
);
	import ros_pkg::*;

	logic                     vld_s2;
	logic signed [EDGE_W-1:0] el_s2;
	logic signed [EDGE_W-1:0] er_s2;
	logic signed [EDGE_W-1:0] et_s2;
	logic signed [EDGE_W-1:0] eb_s2;
	logic                     xs;
	logic                     ys;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s2 <= 1'b0;
		end else begin
			act_s2 <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		vld_s2  <= vld_s1;
		idx_s2  <= idx_s1;
		kind_s2 <= slot_s1.kind;
		el_s2   <= EDGE_W'(slot_s1.x);
		et_s2   <= EDGE_W'(slot_s1.y);
		er_s2   <= EDGE_W'(slot_s1.x) + EDGE_W'($signed({1'b0, slot_s1.w}));
		eb_s2   <= EDGE_W'(slot_s1.y) + EDGE_W'($signed({1'b0, slot_s1.h}));
	end

	// either box edge strictly inside the slot span
	assign xs = (box.left  > el_s2 && box.left  < er_s2) ||
	            (box.right > el_s2 && box.right < er_s2);
	assign ys = (box.top    > et_s2 && box.top    < eb_s2) ||
	            (box.bottom > et_s2 && box.bottom < eb_s2);

	assign hit_s2 = act_s2 && vld_s2 && xs && ys;

endmodule
